[sv/bbf_pkg.sv]
package bbf_pkg;

    // line length limit and derived widths
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_W       = 11;
    localparam int COORD_W     = 10;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
    localparam logic [CFG_W-1:0] DIM_MIN      = 11'd3;

    // 2^16 / 9 rounded up, exact for sums up to 9 * 255
    localparam logic [12:0] RECIP_9 = 13'd7282;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_px;

    typedef struct packed {
        t_px                px;
        logic [COL_W-1:0]   idx;
        logic               emit;
        logic [COORD_W-1:0] out_col;
        logic [COORD_W-1:0] out_row;
        logic               last;
    } t_item;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    // clamp a dimension register and return the index of its last element
    function automatic logic [COL_W-1:0] last_col_of(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        if (v < DIM_MIN) begin
            c = DIM_MIN;
        end else if (32'(v) > MAX_WIDTH) begin
            c = CFG_W'(MAX_WIDTH);
        end else begin
            c = v;
        end
        return COL_W'(c - CFG_W'(1));
    endfunction

    function automatic logic [ROW_W-1:0] last_row_of(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] c;
        if (v < DIM_MIN) begin
            c = DIM_MIN;
        end else if (32'(v) > MAX_HEIGHT) begin
            c = CFG_W'(MAX_HEIGHT);
        end else begin
            c = v;
        end
        return ROW_W'(c - CFG_W'(1));
    endfunction

    // truncating divide by nine through a reciprocal multiply
    function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+12:0] p;
        p = (SUM_W+13)'(s) * (SUM_W+13)'(RECIP_9);
        return p[16 +: CHAN_W];
    endfunction

endpackage

[sv/bbf_queue.sv]
module bbf_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  bbf_pkg::t_item     i_item,
    input  logic               i_pop,
    output bbf_pkg::t_item     o_head,
    output bbf_pkg::t_q_status o_status
);
    import bbf_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= QCNT_W'(r_count + 1'b1);
                2'b01:   r_count <= QCNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

[sv/bbf_front.sv]
module bbf_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [bbf_pkg::CHAN_W-1:0] i_red,
    input  logic [bbf_pkg::CHAN_W-1:0] i_green,
    input  logic [bbf_pkg::CHAN_W-1:0] i_blue,
    input  logic                      i_frame_start,
    input  logic                      i_q_full,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_index,
    input  logic [bbf_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_push,
    output bbf_pkg::t_item            o_item
);
    import bbf_pkg::*;

    logic [COL_W-1:0] r_col,      n_col;
    logic [ROW_W-1:0] r_row,      n_row;
    logic [COL_W-1:0] r_last_col;
    logic [ROW_W-1:0] r_last_row;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    logic             w_accept;

    assign w_accept = i_valid && !i_q_full;
    assign o_push   = w_accept;

    // frame start forces the position back to the origin
    assign w_col = i_frame_start ? '0 : r_col;
    assign w_row = i_frame_start ? '0 : r_row;

    always_comb begin
        if (w_col >= r_last_col) begin
            n_col = '0;
            n_row = (w_row >= r_last_row) ? '0 : ROW_W'(w_row + 1'b1);
        end else begin
            n_col = COL_W'(w_col + 1'b1);
            n_row = w_row;
        end
    end

    always_comb begin
        o_item.px.red   = i_red;
        o_item.px.green = i_green;
        o_item.px.blue  = i_blue;
        o_item.idx      = w_col;
        o_item.emit     = (w_col >= COL_W'(2)) && (w_row >= ROW_W'(2));
        o_item.out_col  = COORD_W'(w_col - 1'b1);
        o_item.out_row  = COORD_W'(w_row - 1'b1);
        o_item.last     = (w_col == r_last_col) && (w_row == r_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_last_col <= last_col_of(WIDTH_RESET);
            r_last_row <= last_row_of(HEIGHT_RESET);
        end else begin
            if (w_accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_last_col <= last_col_of(i_cfg_data);
                    CFG_IMAGE_HEIGHT: r_last_row <= last_row_of(i_cfg_data);
                    default:          r_last_col <= r_last_col;
                endcase
            end
        end
    end

endmodule

[sv/bbf_back.sv]
module bbf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bbf_pkg::t_item              i_head,
    input  logic                        i_q_empty,
    output logic                        o_pop,
    input  logic                        i_stall,
    output logic                        o_valid,
    output logic [bbf_pkg::CHAN_W-1:0]  o_red_out,
    output logic [bbf_pkg::CHAN_W-1:0]  o_green_out,
    output logic [bbf_pkg::CHAN_W-1:0]  o_blue_out,
    output logic [bbf_pkg::COORD_W-1:0] o_out_col,
    output logic [bbf_pkg::COORD_W-1:0] o_out_row,
    output logic                        o_frame_last
);
    import bbf_pkg::*;

    // line stores: row above and two rows above
    t_px   r_store_a [MAX_WIDTH];
    t_px   r_store_b [MAX_WIDTH];

    t_px   r_rd_a;
    t_px   r_rd_b;
    t_item r_s2;
    logic  r_s2_valid;
    logic  r_fwd;
    t_px   r_fwd_a;
    t_px   r_fwd_b;
    t_px   r_win [6];

    logic [SUM_W-1:0]   r_sum_r, r_sum_g, r_sum_b;
    logic [COORD_W-1:0] r_s3_col, r_s3_row;
    logic               r_s3_last;
    logic               r_s3_valid;

    logic               w_adv;
    t_px                w_top;
    t_px                w_mid;
    t_px                w_nine [9];
    logic [SUM_W-1:0]   w_sum_r, w_sum_g, w_sum_b;

    assign w_adv = !o_valid || !i_stall;
    assign o_pop = w_adv && !i_q_empty;

    // bypass when the previous pixel wrote the same column as this one was read
    assign w_mid = r_fwd ? r_fwd_a : r_rd_a;
    assign w_top = r_fwd ? r_fwd_b : r_rd_b;

    always_comb begin
        w_nine[0] = r_win[0]; w_nine[1] = r_win[1]; w_nine[2] = w_top;
        w_nine[3] = r_win[2]; w_nine[4] = r_win[3]; w_nine[5] = w_mid;
        w_nine[6] = r_win[4]; w_nine[7] = r_win[5]; w_nine[8] = r_s2.px;
        w_sum_r = '0;
        w_sum_g = '0;
        w_sum_b = '0;
        for (int k = 0; k < 9; k++) begin
            w_sum_r = SUM_W'(w_sum_r + SUM_W'(w_nine[k].red));
            w_sum_g = SUM_W'(w_sum_g + SUM_W'(w_nine[k].green));
            w_sum_b = SUM_W'(w_sum_b + SUM_W'(w_nine[k].blue));
        end
    end

    // line store ports
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rd_a <= r_store_a[i_head.idx];
            r_rd_b <= r_store_b[i_head.idx];
            if (r_s2_valid) begin
                r_store_a[r_s2.idx] <= r_s2.px;
                r_store_b[r_s2.idx] <= w_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2    <= i_head;
            r_fwd_a <= r_s2.px;
            r_fwd_b <= w_mid;
            r_sum_r  <= w_sum_r;
            r_sum_g  <= w_sum_g;
            r_sum_b  <= w_sum_b;
            r_s3_col  <= r_s2.out_col;
            r_s3_row  <= r_s2.out_row;
            r_s3_last <= r_s2.last;
            o_red_out    <= div9(r_sum_r);
            o_green_out  <= div9(r_sum_g);
            o_blue_out   <= div9(r_sum_b);
            o_out_col    <= r_s3_col;
            o_out_row    <= r_s3_row;
            o_frame_last <= r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_fwd      <= 1'b0;
            r_s3_valid <= 1'b0;
            o_valid    <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_adv) begin
            r_s2_valid <= !i_q_empty;
            r_fwd      <= r_s2_valid && (r_s2.idx == i_head.idx);
            r_s3_valid <= r_s2_valid && r_s2.emit;
            o_valid    <= r_s3_valid;
            if (r_s2_valid) begin
                r_win[0] <= r_win[1];
                r_win[1] <= w_top;
                r_win[2] <= r_win[3];
                r_win[3] <= w_mid;
                r_win[4] <= r_win[5];
                r_win[5] <= r_s2.px;
            end
        end
    end

endmodule

[sv/box_blur_rgb_filter_top.sv]
// streaming 3x3 box blur on rgb pixels in raster order. one pixel transfer is
// taken per clock while o_stall is low. the pixel that completes a neighbourhood
// passes the queue, window, sum and output registers; the rate is set by the line
// stores, which see one read and one write per pixel. positions in the first and
// last row and column get no result, so each frame yields (width-2)*(height-2)
// results. frame_start sets the position to the origin; without it the next frame
// follows the last pixel of the previous one. configuration (index 0 image width,
// 1 image height, each clamped to 3..1024) is always ready and should only be
// written while no pixel is in flight. the line stores are not cleared after
// reset: the first two rows of a frame fill them before any result reads them
module box_blur_rgb_filter_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [bbf_pkg::CHAN_W-1:0]  i_red,
    input  logic [bbf_pkg::CHAN_W-1:0]  i_green,
    input  logic [bbf_pkg::CHAN_W-1:0]  i_blue,
    input  logic                        i_frame_start,
    // blurred pixel output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [bbf_pkg::CHAN_W-1:0]  o_red_out,
    output logic [bbf_pkg::CHAN_W-1:0]  o_green_out,
    output logic [bbf_pkg::CHAN_W-1:0]  o_blue_out,
    output logic [bbf_pkg::COORD_W-1:0] o_out_col,
    output logic [bbf_pkg::COORD_W-1:0] o_out_row,
    output logic                        o_frame_last,
    // configuration write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [bbf_pkg::CFG_W-1:0]   i_cfg_data
);
    import bbf_pkg::*;

    logic      w_push;
    logic      w_pop;
    t_item     w_item;
    t_item     w_head;
    t_q_status w_qstat;

    // registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // input side stalls only when the queue is full
    assign o_stall = w_qstat.full;

    // front: position tracking, border classification, coordinates
    bbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_start (i_frame_start),
        .i_q_full      (w_qstat.full),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_push        (w_push),
        .o_item        (w_item)
    );

    // short queue so the front keeps taking pixels while the output is held
    bbf_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    // back: line stores, window, sums, divide by nine, output register
    bbf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_q_empty    (w_qstat.empty),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last)
    );

    // a result never sits on the border
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_col != '0) && (o_out_row != '0))
        else $error("result reported on a border position");

    // queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // a held result freezes the back end
    a_no_pop_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> !w_pop)
        else $error("queue popped while output held");

    // a full queue is never written
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full |-> !w_push)
        else $error("push into full queue");

endmodule
